// ===== sv/cmsc_pkg.sv =====
// Shared widths, constants and sequencer states for the clock multiplier/shift calculator.
`timescale 1ns / 1ps
`default_nettype none

package cmsc_pkg;

    // Width of the frequency, range and multiplier words.
    localparam int WORD_W = 32;
    // Width of the shift result, which runs from 0 to WORD_W.
    localparam int SHIFT_W = 6;
    // Width of the trial quotient and of the dividend.
    localparam int DWORD_W = 2 * WORD_W;
    // Width of the bit counter of the serial divider.
    localparam int CNT_W = $clog2(DWORD_W);

    // Largest trial shift; the search starts here.
    localparam logic [SHIFT_W-1:0] MAX_SHIFT = SHIFT_W'(WORD_W);
    // Last bit position handled by the serial divider.
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DWORD_W - 1);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MULT  = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_SETUP = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// ===== sv/clock_mult_shift_calc.sv =====
// Top level: multiplier and shift search for scaled frequency conversion.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+---------------------------------------------
//   input   | in_valid, in_ready  | source_hz, target_hz, range_seconds
//   output  | out_valid, out_ready| multiplier, shift_amount, divide_error
//
// One item is handled at a time; in_ready is high only while the sequencer idles.
// A zero source gives its result in the cycle after the transfer.
// Otherwise: the range product is formed, the bit length L of its upper half is measured
// one bit at a time, then each trial shift runs a dividend set-up, 64 steps of the
// shared restoring divider and one fit check, with at most 32 trials.
// Reset clears the sequencer only; a stalled result holds until out_ready takes it.
`timescale 1ns / 1ps
`default_nettype none

module clock_mult_shift_calc (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             in_valid,
    output logic                            in_ready,
    input  wire  [cmsc_pkg::WORD_W-1:0]     source_hz,
    input  wire  [cmsc_pkg::WORD_W-1:0]     target_hz,
    input  wire  [cmsc_pkg::WORD_W-1:0]     range_seconds,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [cmsc_pkg::WORD_W-1:0]     multiplier,
    output logic [cmsc_pkg::SHIFT_W-1:0]    shift_amount,
    output logic                            divide_error
);

    import cmsc_pkg::*;

    state_t               state_reg, state_next;
    logic [WORD_W-1:0]    src_reg, src_next;
    logic [WORD_W-1:0]    dst_reg, dst_next;
    logic [WORD_W-1:0]    rng_reg, rng_next;
    logic [WORD_W-1:0]    hi_reg, hi_next;
    logic [SHIFT_W-1:0]   len_reg, len_next;
    logic [SHIFT_W-1:0]   s_reg, s_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_W-1:0]    rem_reg, rem_next;
    logic [DWORD_W-1:0]   num_reg, num_next;
    logic [WORD_W-1:0]    mult_reg, mult_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic                 err_reg, err_next;

    logic [DWORD_W-1:0]   product;
    logic [DWORD_W-1:0]   dividend;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;
    logic                 take;
    logic [SHIFT_W-1:0]   limit;
    logic                 fits;

    // Range product for the accumulator limit.
    assign product = DWORD_W'(rng_reg) * DWORD_W'(src_reg);

    // Rounded dividend for the current trial shift.
    assign dividend = (DWORD_W'(dst_reg) << s_reg) + DWORD_W'(src_reg >> 1);

    // One restoring division step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, num_reg[DWORD_W-1]};
    assign diff  = trial - {1'b0, src_reg};
    assign take  = (trial >= {1'b0, src_reg});

    // Accumulator limit and fit test of the finished quotient.
    assign limit = MAX_SHIFT - len_reg;
    assign fits  = ((num_reg >> limit) == '0);

    // Sequencer next-state and datapath selection.
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        rng_next   = rng_reg;
        hi_next    = hi_reg;
        len_next   = len_reg;
        s_next     = s_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        mult_next  = mult_reg;
        shift_next = shift_reg;
        err_next   = err_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    src_next = source_hz;
                    dst_next = target_hz;
                    rng_next = range_seconds;
                    if (source_hz == '0)
                    begin
                        mult_next  = '0;
                        shift_next = '0;
                        err_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = ST_MULT;
                    end
                end
            end
            ST_MULT:
            begin
                hi_next    = product[DWORD_W-1:WORD_W];
                len_next   = '0;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                // Count the bit length of the upper product half, one bit a cycle.
                if (hi_reg == '0)
                begin
                    s_next     = MAX_SHIFT;
                    state_next = ST_SETUP;
                end
                else
                begin
                    hi_next  = hi_reg >> 1;
                    len_next = len_reg + 1'b1;
                end
            end
            ST_SETUP:
            begin
                num_next   = dividend;
                rem_next   = '0;
                cnt_next   = LAST_BIT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Quotient bits shift in at the bottom as dividend bits leave the top.
                rem_next = take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                num_next = {num_reg[DWORD_W-2:0], take};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Stop at the first quotient under the limit, or after the last trial.
                if (fits || (s_reg == SHIFT_W'(1)))
                begin
                    mult_next  = num_reg[WORD_W-1:0];
                    shift_next = fits ? s_reg : '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    s_next     = s_reg - 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        dst_reg   <= dst_next;
        rng_reg   <= rng_next;
        hi_reg    <= hi_next;
        len_reg   <= len_next;
        s_reg     <= s_next;
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        num_reg   <= num_next;
        mult_reg  <= mult_next;
        shift_reg <= shift_next;
        err_reg   <= err_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_DONE);
    assign multiplier   = mult_reg;
    assign shift_amount = shift_reg;
    assign divide_error = err_reg;

    // The block never takes a new transfer while a result waits.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    // The partial remainder stays below the divisor throughout a division.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < src_reg))
        else $error("divider remainder out of range");

    // A reported shift never exceeds the word width.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shift_amount <= MAX_SHIFT))
        else $error("shift result out of range");

    // A zero source gives zero results.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && divide_error) |-> ((multiplier == '0) && (shift_amount == '0)))
        else $error("error result carries nonzero fields");

    // A nonzero source never yields a result in the cycle right after its transfer.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (source_hz != '0)) |=> !out_valid)
        else $error("result appeared before the search ran");

endmodule

`default_nettype wire
